// ===== rtl/ufr_pkg.sv =====
// ----------------------------------------------------------------------------
// ufr_pkg
// shared types, constants and the crc-8 byte update for the datagram framer
// ----------------------------------------------------------------------------
package ufr_pkg;

  // operation codes carried on the request channel
  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_REPLY = 2'd2
  } op_e;

  localparam logic [7:0] SYNC_BYTE  = 8'h05;
  localparam logic [7:0] CRC_POLY   = 8'h07;
  localparam logic [7:0] WRITE_FLAG = 8'h80;

  // byte position inside a datagram
  typedef logic [2:0] byte_idx_t;

  localparam byte_idx_t WRITE_LAST       = 3'd7;
  localparam byte_idx_t READ_LAST        = 3'd3;
  localparam byte_idx_t REPLY_FIRST_DATA = 3'd3;
  localparam byte_idx_t REPLY_LAST       = 3'd7;

  // one reply byte handed to the checker
  typedef struct packed {
    logic       step;
    logic [7:0] rx;
  } reply_req_t;

  // checker status seen by the framer
  typedef struct packed {
    logic        complete;
    logic [31:0] data;
    logic        crc_match;
  } reply_status_t;

  // crc-8, poly 0x07, byte fed lsb first
  function automatic logic [7:0] crc_feed(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc;
    for (int i = 0; i < 8; i++) begin
      if (c[7] ^ data[i]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ===== rtl/ufr_in_if.sv =====
// ----------------------------------------------------------------------------
// ufr_in_if
// request channel: operation plus request and reply byte payload
// ----------------------------------------------------------------------------
interface ufr_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [1:0]  node_address;
  logic [6:0]  register_index;
  logic [31:0] write_data;
  logic [7:0]  reply_byte;

  modport source (
    output valid, operation, node_address, register_index, write_data, reply_byte,
    input  ready
  );

  modport sink (
    input  valid, operation, node_address, register_index, write_data, reply_byte,
    output ready
  );
endinterface

// ===== rtl/ufr_out_if.sv =====
// ----------------------------------------------------------------------------
// ufr_out_if
// result channel: transmit bytes and completed reply reports
// ----------------------------------------------------------------------------
interface ufr_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic        last_item;
  logic        is_reply_result;
  logic [31:0] reply_data;
  logic        crc_match;

  modport source (
    output valid, out_byte, last_item, is_reply_result, reply_data, crc_match,
    input  ready
  );

  modport sink (
    input  valid, out_byte, last_item, is_reply_result, reply_data, crc_match,
    output ready
  );
endinterface

// ===== rtl/ufr_reply_checker.sv =====
// ----------------------------------------------------------------------------
// ufr_reply_checker
// collects reply bytes eight at a time, running crc and big-endian data word
// ----------------------------------------------------------------------------
module ufr_reply_checker (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  ufr_pkg::reply_req_t    req_i,
  output ufr_pkg::reply_status_t status_o
);

  ufr_pkg::byte_idx_t count_q, count_d;
  logic [7:0]         crc_q, crc_d;
  logic [31:0]        word_q, word_d;
  logic               complete;

  assign complete = (count_q == ufr_pkg::REPLY_LAST);

  assign status_o.complete  = complete;
  assign status_o.data      = word_q;
  assign status_o.crc_match = (req_i.rx == crc_q);

  always_comb begin
    count_d = count_q;
    crc_d   = crc_q;
    word_d  = word_q;
    if (req_i.step) begin
      if (complete) begin
        count_d = '0;
        crc_d   = '0;
        word_d  = '0;
      end else begin
        count_d = count_q + 3'd1;
        crc_d   = ufr_pkg::crc_feed(crc_q, req_i.rx);
        if (count_q >= ufr_pkg::REPLY_FIRST_DATA) begin
          word_d = {word_q[23:0], req_i.rx};
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      crc_q   <= '0;
      word_q  <= '0;
    end else begin
      count_q <= count_d;
      crc_q   <= crc_d;
      word_q  <= word_d;
    end
  end

  // the eighth byte leaves the collector empty
  a_clear_after_complete : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.step && complete) |=> (count_q == '0 && crc_q == '0 && word_q == '0))
    else $error("reply state not cleared after eighth byte");

  // no byte, no progress
  a_hold_when_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !req_i.step |=> ($stable(count_q) && $stable(crc_q) && $stable(word_q)))
    else $error("reply state moved without a reply byte");

endmodule

// ===== rtl/uart_register_datagram_framer.sv =====
// ----------------------------------------------------------------------------
// uart_register_datagram_framer
// builds read/write register datagrams and checks eight-byte replies
// ----------------------------------------------------------------------------
// usage:
//   in_i carries one beat per operation: a write request (8 bytes out), a
//   read request (4 bytes out) or one received reply byte. out_o carries one
//   beat per transmit byte, plus one report beat after every eighth reply byte.
//   a beat is taken when valid and ready are both high.
// path: an accepted beat lands in the job register; its first result beat
//   is then loaded into the output register, which drives out_o.
// throughput: a write request holds the job register until its 8 bytes have left,
//   a read request until its 4 have; a reply byte or an unused operation leaves
//   it as soon as it steps. the byte serializer sets this: one datagram byte
//   leaves per cycle while out_o takes beats, the crc updated byte by byte as it
//   goes. the next beat is taken in the cycle the current job takes its last step.
// reset: clears the job and output valid flags, the byte counter, the transmit
//   crc and the reply collector; no clearing pass is needed.
// stall: while out_o.ready is low the output register holds its beat, the
//   serializer stops and in_i.ready drops once the job register is busy.
// ----------------------------------------------------------------------------
module uart_register_datagram_framer (
  input  logic      clk_i,
  input  logic      rst_ni,
  ufr_in_if.sink    in_i,
  ufr_out_if.source out_o
);

  // job register (input stage)
  logic               job_valid_q;
  logic [1:0]         job_op_q;
  logic [1:0]         job_addr_q;
  logic [6:0]         job_reg_q;
  logic [31:0]        job_data_q;
  logic [7:0]         job_rx_q;

  // serializer state
  ufr_pkg::byte_idx_t idx_q, idx_d;
  logic [7:0]         tx_crc_q, tx_crc_d;

  // output register
  logic               out_valid_q;
  logic [7:0]         out_byte_q;
  logic               out_last_q;
  logic               out_reply_q;
  logic [31:0]        out_rdata_q;
  logic               out_match_q;

  // step control
  logic               slot_free;
  logic               step;
  logic               is_request;
  logic               is_write;
  logic               emit;
  logic               last_step;
  logic               job_done;
  logic [7:0]         req_byte;
  logic               in_beat;

  ufr_pkg::reply_req_t    reply_req;
  ufr_pkg::reply_status_t reply_status;

  // output slot can take a beat when empty or draining this cycle
  assign slot_free = !out_valid_q || out_o.ready;
  assign step      = job_valid_q && slot_free;
  assign job_done  = step && last_step;
  assign in_beat   = in_i.valid && in_i.ready;

  // new job may enter while the previous one hands over its final beat
  assign in_i.ready = !job_valid_q || job_done;

  // request byte at the current position
  always_comb begin
    case (idx_q)
      3'd0:    req_byte = ufr_pkg::SYNC_BYTE;
      3'd1:    req_byte = {6'd0, job_addr_q};
      3'd2:    req_byte = is_write ? (ufr_pkg::WRITE_FLAG | {1'b0, job_reg_q})
                                   : {1'b0, job_reg_q};
      3'd3:    req_byte = is_write ? job_data_q[31:24] : tx_crc_q;
      3'd4:    req_byte = job_data_q[23:16];
      3'd5:    req_byte = job_data_q[15:8];
      3'd6:    req_byte = job_data_q[7:0];
      3'd7:    req_byte = tx_crc_q;
      default: req_byte = tx_crc_q;
    endcase
  end

  // decode of the held operation
  always_comb begin
    is_request = 1'b0;
    is_write   = 1'b0;
    emit       = 1'b0;
    last_step  = 1'b1;
    case (ufr_pkg::op_e'(job_op_q))
      ufr_pkg::OP_WRITE: begin
        is_request = 1'b1;
        is_write   = 1'b1;
        emit       = 1'b1;
        last_step  = (idx_q == ufr_pkg::WRITE_LAST);
      end
      ufr_pkg::OP_READ: begin
        is_request = 1'b1;
        emit       = 1'b1;
        last_step  = (idx_q == ufr_pkg::READ_LAST);
      end
      ufr_pkg::OP_REPLY: begin
        // only the eighth reply byte yields a report
        emit      = reply_status.complete;
        last_step = 1'b1;
      end
      default: begin
        // unused code: consumed silently
        emit      = 1'b0;
        last_step = 1'b1;
      end
    endcase
  end

  // byte counter and running transmit crc
  always_comb begin
    idx_d    = idx_q;
    tx_crc_d = tx_crc_q;
    if (step && is_request) begin
      if (last_step) begin
        idx_d    = '0;
        tx_crc_d = '0;
      end else begin
        idx_d    = idx_q + 3'd1;
        tx_crc_d = ufr_pkg::crc_feed(tx_crc_q, req_byte);
      end
    end
  end

  // reply collector sees each reply byte once, when its job steps
  assign reply_req.step = step && (job_op_q == ufr_pkg::OP_REPLY);
  assign reply_req.rx   = job_rx_q;

  ufr_reply_checker u_reply_checker (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (reply_req),
    .status_o (reply_status)
  );

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_valid_q <= 1'b0;
      idx_q       <= '0;
      tx_crc_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_beat) begin
        job_valid_q <= 1'b1;
      end else if (job_done) begin
        job_valid_q <= 1'b0;
      end
      idx_q    <= idx_d;
      tx_crc_q <= tx_crc_d;
      if (slot_free) begin
        out_valid_q <= step && emit;
      end
    end
  end

  // job payload
  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      job_op_q   <= in_i.operation;
      job_addr_q <= in_i.node_address;
      job_reg_q  <= in_i.register_index;
      job_data_q <= in_i.write_data;
      job_rx_q   <= in_i.reply_byte;
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    if (step && emit) begin
      out_byte_q  <= is_request ? req_byte : 8'd0;
      out_last_q  <= last_step;
      out_reply_q <= !is_request;
      out_rdata_q <= is_request ? 32'd0 : reply_status.data;
      out_match_q <= is_request ? 1'b0 : reply_status.crc_match;
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.out_byte        = out_byte_q;
  assign out_o.last_item       = out_last_q;
  assign out_o.is_reply_result = out_reply_q;
  assign out_o.reply_data      = out_rdata_q;
  assign out_o.crc_match       = out_match_q;

  // a byte position in flight means a job is held
  a_idx_needs_job : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (idx_q != '0) |-> job_valid_q)
    else $error("byte counter busy without a job");

  // a read request never runs past its crc byte
  a_read_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (job_valid_q && job_op_q == ufr_pkg::OP_READ) |-> (idx_q <= ufr_pkg::READ_LAST))
    else $error("read request past its last byte");

  // finishing a request rewinds the serializer
  a_rewind : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (job_done && is_request) |=> (idx_q == '0 && tx_crc_q == '0))
    else $error("serializer not rewound after request");

  // a reply report is always a final beat
  a_reply_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_reply_q) |-> out_last_q)
    else $error("reply report without final flag");

endmodule

// ===== verif/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the uart register datagram framer: a queue-fed
// driver offers write, read, reply-byte and unused beats with random gaps, a
// monitor stalls the result side at random and compares every result beat
// field by field against a bench-side model of framing, crc-8 and replies
// ----------------------------------------------------------------------------
module tb_top;

  // operation code the block must swallow without any result
  localparam logic [1:0] OP_IGNORED = 2'd3;

  localparam int RESET_CYCLES   = 12;
  localparam int RANDOM_BEATS   = 85;   // counted without ignored beats
  localparam int TAIL_BEATS     = 16;   // no idling on either side once this few are left
  localparam int HOLD_AT_BEAT   = 40;   // long result-side hold-off starts here
  localparam int HOLD_CYCLES    = 80;
  localparam int MAX_GAP        = 13;
  localparam int DRAIN_CYCLES   = 24;   // quiet wait after the last expected result beat
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int SHOWN_FAULTS   = 10;

  // one beat offered on the request channel
  typedef struct {
    logic [1:0]  op;
    logic [1:0]  addr;
    logic [6:0]  reg_idx;
    logic [31:0] wdata;
    logic [7:0]  rx;
  } in_beat_t;

  // one beat seen on the result channel
  typedef struct {
    logic [7:0]  tx_byte;
    logic        last;
    logic        reply_done;
    logic [31:0] word;
    logic        crc_ok;
  } out_beat_t;

  logic clk_i;
  logic rst_ni;

  ufr_in_if  in_if ();
  ufr_out_if out_if ();

  uart_register_datagram_framer u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  // stimulus and expectation stores
  in_beat_t  pending_ops[$];
  out_beat_t awaited_beats[$];

  // bench copy of the reply collector
  logic [2:0]  rx_count;
  logic [7:0]  rx_crc;
  logic [31:0] rx_word;

  // generator bookkeeping
  int         planned_items;
  logic [2:0] rx_phase_plan;  // reply byte position the queued beats will reach
  int         total_beats;

  // run statistics
  int n_writes, n_reads, n_reply_bytes, n_ignored, n_reports, n_crc_ok;
  int beats_in, beats_out, fail_count;

  // driver state
  in_beat_t cur_beat;
  int       src_gap;
  logic     quiet_tail;

  // monitor and hold-off state
  int   snk_gap;
  logic hold_off, hold_used;
  int   hold_cycles;
  int   stall_cycles;

  // ---------------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------------

  // crc-8 with poly 0x07, zero start, data bits taken lsb first
  function automatic logic [7:0] crc8_step(input logic [7:0] acc, input logic [7:0] b);
    logic [7:0] r;
    logic       fb;
    r = acc;
    for (int k = 0; k < 8; k++) begin
      fb = r[7] ^ b[k];
      r  = {r[6:0], 1'b0} ^ (fb ? ufr_pkg::CRC_POLY : 8'h00);
    end
    return r;
  endfunction

  // works out the result beats of one accepted request-channel beat
  task automatic predict_datagram(input in_beat_t b);
    logic [7:0] frame[8];
    logic [7:0] crc;
    int         n;
    out_beat_t  r;
    if (b.op == ufr_pkg::OP_WRITE || b.op == ufr_pkg::OP_READ) begin
      frame[0] = ufr_pkg::SYNC_BYTE;
      frame[1] = {6'd0, b.addr};
      if (b.op == ufr_pkg::OP_WRITE) begin
        // write: register with the write flag, then data msb first
        frame[2] = ufr_pkg::WRITE_FLAG | {1'b0, b.reg_idx};
        frame[3] = b.wdata[31:24];
        frame[4] = b.wdata[23:16];
        frame[5] = b.wdata[15:8];
        frame[6] = b.wdata[7:0];
        n = int'(ufr_pkg::WRITE_LAST);
        n_writes++;
      end else begin
        frame[2] = {1'b0, b.reg_idx};
        n = int'(ufr_pkg::READ_LAST);
        n_reads++;
      end
      crc = 8'h00;
      for (int k = 0; k < n; k++) crc = crc8_step(crc, frame[k]);
      frame[n] = crc;
      for (int k = 0; k <= n; k++) begin
        r.tx_byte    = frame[k];
        r.last       = (k == n);
        r.reply_done = 1'b0;
        r.word       = 32'd0;
        r.crc_ok     = 1'b0;
        awaited_beats.push_back(r);
      end
    end else if (b.op == ufr_pkg::OP_REPLY) begin
      n_reply_bytes++;
      if (rx_count != ufr_pkg::REPLY_LAST) begin
        // bytes before the eighth only update the collector
        rx_crc = crc8_step(rx_crc, b.rx);
        if (rx_count >= ufr_pkg::REPLY_FIRST_DATA) rx_word = {rx_word[23:0], b.rx};
        rx_count = rx_count + 3'd1;
      end else begin
        // eighth byte: report and start over
        r.tx_byte    = 8'h00;
        r.last       = 1'b1;
        r.reply_done = 1'b1;
        r.word       = rx_word;
        r.crc_ok     = (b.rx == rx_crc);
        awaited_beats.push_back(r);
        n_reports++;
        if (r.crc_ok) n_crc_ok++;
        rx_count = 3'd0;
        rx_crc   = 8'h00;
        rx_word  = 32'd0;
      end
    end else begin
      n_ignored++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // stimulus builders
  // ---------------------------------------------------------------------------

  function automatic void queue_beat(input logic [1:0] op, input logic [1:0] addr,
                                     input logic [6:0] reg_idx, input logic [31:0] wdata,
                                     input logic [7:0] rx);
    in_beat_t b;
    b.op      = op;
    b.addr    = addr;
    b.reg_idx = reg_idx;
    b.wdata   = wdata;
    b.rx      = rx;
    pending_ops.push_back(b);
    if (op != OP_IGNORED) planned_items++;
    if (op == ufr_pkg::OP_REPLY) rx_phase_plan = rx_phase_plan + 3'd1;
  endfunction

  function automatic void queue_random_request();
    queue_beat(($urandom_range(0, 1) == 0) ? ufr_pkg::OP_WRITE : ufr_pkg::OP_READ,
               2'($urandom), 7'($urandom), $urandom, 8'($urandom));
  endfunction

  function automatic void queue_ignored();
    queue_beat(OP_IGNORED, 2'($urandom), 7'($urandom), $urandom, 8'($urandom));
  endfunction

  function automatic void queue_stray_byte();
    queue_beat(ufr_pkg::OP_REPLY, 2'($urandom), 7'($urandom), $urandom, 8'($urandom));
  endfunction

  // eight reply bytes: body is bytes 0..6 msb first, the crc byte is appended;
  // split_at in 1..6 slips a request and an ignored beat in before that byte
  function automatic void queue_reply(input logic [55:0] body, input bit bad_crc,
                                      input int split_at);
    logic [7:0] b;
    logic [7:0] crc;
    crc = 8'h00;
    for (int k = 0; k < 7; k++) begin
      b = body[55 - 8 * k -: 8];
      if (split_at > 0 && k == split_at) begin
        queue_random_request();
        queue_ignored();
      end
      crc = crc8_step(crc, b);
      queue_beat(ufr_pkg::OP_REPLY, 2'($urandom), 7'($urandom), $urandom, b);
    end
    if (bad_crc) crc = crc ^ 8'($urandom_range(1, 255));
    queue_beat(ufr_pkg::OP_REPLY, 2'($urandom), 7'($urandom), $urandom, crc);
  endfunction

  // ---------------------------------------------------------------------------
  // driver: one beat at a time from pending_ops, random gaps after a beat
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    logic offer;
    if (!rst_ni) begin
      in_if.valid          <= 1'b0;
      in_if.operation      <= 2'd0;
      in_if.node_address   <= 2'd0;
      in_if.register_index <= 7'd0;
      in_if.write_data     <= 32'd0;
      in_if.reply_byte     <= 8'd0;
      beats_in             <= 0;
      quiet_tail           <= 1'b0;
      src_gap = 0;
    end else begin
      offer = in_if.valid;
      if (in_if.valid && in_if.ready) begin
        // beat taken: model it now, before any of its results can appear
        predict_datagram(cur_beat);
        beats_in <= beats_in + 1;
        offer = 1'b0;
        if (!quiet_tail && $urandom_range(0, 3) == 0) src_gap = $urandom_range(1, MAX_GAP);
      end
      if (!offer) begin
        if (src_gap > 0) begin
          src_gap--;
        end else if (pending_ops.size() != 0) begin
          cur_beat = pending_ops.pop_front();
          offer = 1'b1;
          in_if.operation      <= cur_beat.op;
          in_if.node_address   <= cur_beat.addr;
          in_if.register_index <= cur_beat.reg_idx;
          in_if.write_data     <= cur_beat.wdata;
          in_if.reply_byte     <= cur_beat.rx;
        end
      end
      // single update of valid per edge, so back-to-back beats keep it high
      in_if.valid <= offer;
      quiet_tail  <= (pending_ops.size() <= TAIL_BEATS);
    end
  end

  // ---------------------------------------------------------------------------
  // result-side hold-off: one long stretch with ready low so the block backs up
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_off    <= 1'b0;
      hold_used   <= 1'b0;
      hold_cycles <= 0;
    end else if (hold_off) begin
      if (hold_cycles == HOLD_CYCLES - 1) hold_off <= 1'b0;
      hold_cycles <= hold_cycles + 1;
    end else if (!hold_used && beats_in >= HOLD_AT_BEAT) begin
      hold_off    <= 1'b1;
      hold_used   <= 1'b1;
      hold_cycles <= 0;
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: checks each result beat against the oldest expectation
  // ---------------------------------------------------------------------------
  task automatic log_fault(input string what, input out_beat_t want, input out_beat_t got);
    fail_count++;
    if (fail_count <= SHOWN_FAULTS) begin
      $display("out beat %0d %s: expected byte %02h last %b reply %b data %08h crc_ok %b",
               beats_out, what, want.tx_byte, want.last, want.reply_done, want.word,
               want.crc_ok);
      $display("  got byte %02h last %b reply %b data %08h crc_ok %b",
               got.tx_byte, got.last, got.reply_done, got.word, got.crc_ok);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_beat_t got;
    out_beat_t want;
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      beats_out    <= 0;
      snk_gap = 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        got.tx_byte    = out_if.out_byte;
        got.last       = out_if.last_item;
        got.reply_done = out_if.is_reply_result;
        got.word       = out_if.reply_data;
        got.crc_ok     = out_if.crc_match;
        beats_out <= beats_out + 1;
        if (awaited_beats.size() == 0) begin
          want = '{default: '0};
          log_fault("with nothing expected", want, got);
        end else begin
          want = awaited_beats.pop_front();
          if (got.tx_byte !== want.tx_byte || got.last !== want.last ||
              got.reply_done !== want.reply_done || got.word !== want.word ||
              got.crc_ok !== want.crc_ok) begin
            log_fault("mismatch", want, got);
          end
        end
      end
      // random stall bursts, none near the end of the run
      if (snk_gap > 0) begin
        snk_gap--;
      end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
        snk_gap = $urandom_range(1, MAX_GAP);
      end
      out_if.ready <= !hold_off && (snk_gap == 0);
    end
  end

  // ---------------------------------------------------------------------------
  // watchdog: too long without a beat on either channel
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (!rst_ni || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles == WATCHDOG_LIMIT) begin
      $display("timeout: no beat for %0d cycles, %0d of %0d input beats taken",
               WATCHDOG_LIMIT, beats_in, total_beats);
      $display("CHECKS FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------
  initial begin
    logic [55:0] body;
    int          pick;
    int          random_end;

    // known levels before the first edge
    rst_ni                = 1'b0;
    in_if.valid           = 1'b0;
    in_if.operation       = 2'd0;
    in_if.node_address    = 2'd0;
    in_if.register_index  = 7'd0;
    in_if.write_data      = 32'd0;
    in_if.reply_byte      = 8'd0;
    out_if.ready          = 1'b0;
    rx_count              = 3'd0;
    rx_crc                = 8'h00;
    rx_word               = 32'd0;
    rx_phase_plan         = 3'd0;
    planned_items         = 0;
    fail_count            = 0;
    n_writes              = 0;
    n_reads               = 0;
    n_reply_bytes         = 0;
    n_ignored             = 0;
    n_reports             = 0;
    n_crc_ok              = 0;
    stall_cycles          = 0;

    // directed: field extremes for both request kinds
    queue_beat(ufr_pkg::OP_WRITE, 2'd0, 7'd0, 32'h0000_0000, 8'h00);
    queue_beat(ufr_pkg::OP_WRITE, 2'd3, 7'd127, 32'hFFFF_FFFF, 8'hFF);
    queue_beat(ufr_pkg::OP_READ, 2'd0, 7'd0, 32'h0000_0000, 8'h00);
    queue_beat(ufr_pkg::OP_READ, 2'd3, 7'd127, 32'hFFFF_FFFF, 8'hFF);
    // unused operation with every field set
    queue_beat(OP_IGNORED, 2'd3, 7'd127, 32'hFFFF_FFFF, 8'hFF);
    // clean reply, crc good
    queue_reply({ufr_pkg::SYNC_BYTE, 8'h03, 8'h7F, 32'hA5C3_0F81}, 1'b0, 0);
    // reply with all-zero and all-one bytes, a request and an unused op
    // slipped in after the third byte, crc corrupted
    queue_reply({8'h00, 8'hFF, 8'h00, 32'hFFFF_FFFF}, 1'b1, 3);

    // random: mostly whole replies and requests, some stray bytes and unused ops
    random_end = planned_items + RANDOM_BEATS;
    while (planned_items < random_end) begin
      pick = $urandom_range(0, 15);
      if (pick < 5) begin
        queue_random_request();
      end else if (pick < 12) begin
        // realign to a reply boundary most of the time, else leave it broken
        if (rx_phase_plan != 3'd0 && $urandom_range(0, 3) != 0) begin
          repeat (8 - int'(rx_phase_plan)) queue_stray_byte();
        end
        body = {(($urandom_range(0, 3) == 0) ? 8'($urandom) : ufr_pkg::SYNC_BYTE),
                8'($urandom), 8'($urandom), 32'($urandom)};
        queue_reply(body, $urandom_range(0, 3) == 0,
                    ($urandom_range(0, 4) == 0) ? $urandom_range(1, 6) : 0);
      end else if (pick < 14) begin
        queue_stray_byte();
      end else begin
        queue_ignored();
      end
    end
    total_beats = pending_ops.size();

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    // every beat taken, then every expectation met, then a quiet drain
    while (beats_in != total_beats) @(posedge clk_i);
    while (awaited_beats.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("run: %0d input beats - %0d writes, %0d reads, %0d reply bytes, %0d unused ops",
             beats_in, n_writes, n_reads, n_reply_bytes, n_ignored);
    $display("run: %0d result beats checked, %0d reply reports (%0d crc good), %0d faults",
             beats_out, n_reports, n_crc_ok, fail_count);
    if (awaited_beats.size() != 0) begin
      fail_count++;
      $display("%0d expected result beats never arrived", awaited_beats.size());
    end
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
